// File: sv/tsol_pkg.sv
// Shared types, codes and constants of the time-scale offset lookup.
`timescale 1ns / 1ps
`default_nettype none

package tsol_pkg;

  // Default table depths.
  localparam int LEAP_ENTRIES_DEF  = 32;
  localparam int DELTA_ENTRIES_DEF = 256;

  // Widths of the count registers and of the config port.
  localparam int LCNT_W  = 6;
  localparam int DCNT_W  = 9;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 1;

  // Config register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEAP_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_COUNT = 1'b1;

  // Input beat layout; tdata from the lowest bit up.
  localparam int IDX_LSB   = 0;
  localparam int YEAR_LSB  = 8;
  localparam int MONTH_LSB = 20;
  localparam int DAY_LSB   = 24;
  localparam int EOFF_LSB  = 29;
  localparam int SCALE_LSB = 47;
  localparam int S_DATA_W  = 56;
  localparam int M_DATA_W  = 24;
  localparam int OFF_W     = 19;
  localparam int EOFF_W    = 18;
  localparam int DATE_W    = 21;

  // Base offsets in milliseconds.
  localparam logic signed [OFF_W-1:0] BASE_TAI_MS = 19'sd32184;
  localparam logic signed [OFF_W-1:0] BASE_GPS_MS = 19'sd51184;

  // Beat kinds carried in the input tuser.
  typedef enum logic [1:0] {
    ACT_LEAP_WR  = 2'd0,
    ACT_DELTA_WR = 2'd1,
    ACT_QUERY    = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  // Time scale codes of a query.
  localparam logic [2:0] SCALE_TT  = 3'd0;
  localparam logic [2:0] SCALE_TAI = 3'd1;
  localparam logic [2:0] SCALE_UTC = 3'd2;
  localparam logic [2:0] SCALE_UT1 = 3'd3;
  localparam logic [2:0] SCALE_GPS = 3'd4;

  // One table entry: packed date {year, month, day} and offset.
  typedef struct packed {
    logic [DATE_W-1:0]        date;
    logic signed [EOFF_W-1:0] offset;
  } tsol_entry_t;

  localparam int ENTRY_W = DATE_W + EOFF_W;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } tsol_state_t;

endpackage

`default_nettype wire

// File: sv/tsol_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tsol_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/time_scale_offset_lookup_core.sv
// Top level of the time-scale offset lookup: table storage and scan sequencer.
//
// Input beats arrive on the s_ group; s_tuser gives the beat kind (leap
// entry write, delta-T entry write, query). Every input beat yields exactly
// one result beat on the m_ group: offset_ms in m_tdata, table_used in m_tuser.
// Counts of valid entries are set on the cfg_ port, by the user only while the
// block is idle; the block does not enforce this. Writes, unknown beat kinds
// and queries that need no table answer in the cycle after the input beat is
// taken. A UTC or UT1 query with a nonzero count scans the table one entry per
// cycle through the memory read port, up to the count limited to the table
// depth; a query year before entry 0's year stops the scan after the first
// entry. One item is worked on at a time: s_tready is high only while the
// sequencer is idle and the output register is free or draining.
// A stalled receiver holds the result in the output register, and a
// finished scan waits for it. Reset clears the sequencer, the counts and
// the output valid; table contents are undefined until written and need
// no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module time_scale_offset_lookup_core import tsol_pkg::*; #(
  parameter int LEAP_ENTRIES  = LEAP_ENTRIES_DEF,
  parameter int DELTA_ENTRIES = DELTA_ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input stream.
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // entry_index[7:0], year[19:8], month[23:20], day[28:24],
  // entry_offset_ms[46:29], scale[49:47], zero fill[55:50]
  input  wire logic [S_DATA_W-1:0]   s_tdata,
  // action[1:0]
  input  wire logic [1:0]            s_tuser,
  // Result stream.
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // offset_ms[18:0], zero fill[23:19]
  output logic [M_DATA_W-1:0]        m_tdata,
  // table_used[0]
  output logic                       m_tuser,
  // Configuration writes.
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  localparam int LAW  = (LEAP_ENTRIES > 1) ? $clog2(LEAP_ENTRIES) : 1;
  localparam int DAW  = (DELTA_ENTRIES > 1) ? $clog2(DELTA_ENTRIES) : 1;
  localparam int MAXD = (LEAP_ENTRIES > DELTA_ENTRIES) ? LEAP_ENTRIES : DELTA_ENTRIES;
  localparam int CW   = $clog2(MAXD + 1);
  localparam int NW   = (CW > DCNT_W) ? CW : DCNT_W;

  // Input fields.
  action_t                  act;
  logic [7:0]               f_idx;
  logic [DATE_W-1:0]        f_date;
  logic signed [EOFF_W-1:0] f_eoff;
  logic [2:0]               f_scale;

  assign act     = action_t'(s_tuser);
  assign f_idx   = s_tdata[IDX_LSB +: 8];
  assign f_date  = {s_tdata[YEAR_LSB +: 12], s_tdata[MONTH_LSB +: 4], s_tdata[DAY_LSB +: 5]};
  assign f_eoff  = s_tdata[EOFF_LSB +: EOFF_W];
  assign f_scale = s_tdata[SCALE_LSB +: 3];

  // Control and datapath registers.
  tsol_state_t              state, state_next;
  logic [LCNT_W-1:0]        leap_count;
  logic [DCNT_W-1:0]        delta_count;
  logic                     s_acc;
  logic                     out_free;
  logic                     out_load;
  logic signed [OFF_W-1:0]  out_off, out_off_next;
  logic                     out_used, out_used_next;
  logic                     scan_sel;
  logic [NW-1:0]            scan_n;
  logic [NW-1:0]            issue_idx;
  logic                     issuing;
  logic                     rd_pend, rd_pend_next;
  logic                     rd_first;
  logic [DATE_W-1:0]        q_date;
  logic signed [OFF_W-1:0]  base;
  logic                     found;
  tsol_entry_t              best;
  tsol_entry_t              cur;
  tsol_entry_t              wr_entry;
  logic [ENTRY_W-1:0]       leap_rd, delta_rd;
  logic                     leap_we, delta_we;
  logic [NW-1:0]            leap_n, delta_n;
  logic                     early, e_le, e_gt;

  // Immediate answer of a beat taken in idle.
  logic signed [OFF_W-1:0]  imm_off;
  logic signed [OFF_W-1:0]  imm_base;
  logic                     need_scan;
  logic                     imm_sel;
  logic [NW-1:0]            imm_n;

  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Counts limited to the table depths.
  assign leap_n  = (NW'(leap_count) > NW'(LEAP_ENTRIES)) ? NW'(LEAP_ENTRIES) : NW'(leap_count);
  assign delta_n = (NW'(delta_count) > NW'(DELTA_ENTRIES)) ?
                   NW'(DELTA_ENTRIES) : NW'(delta_count);

  // Table memories.
  assign wr_entry = '{date: f_date, offset: f_eoff};
  assign leap_we  = s_acc && (act == ACT_LEAP_WR) && (32'(f_idx) < 32'(LEAP_ENTRIES));
  assign delta_we = s_acc && (act == ACT_DELTA_WR) && (32'(f_idx) < 32'(DELTA_ENTRIES));

  tsol_ram #(.WIDTH(ENTRY_W), .DEPTH(LEAP_ENTRIES), .AW(LAW)) u_leap_ram (
    .clk   (clk),
    .we    (leap_we),
    .waddr (LAW'(f_idx)),
    .wdata (wr_entry),
    .raddr (issue_idx[LAW-1:0]),
    .rdata (leap_rd)
  );

  tsol_ram #(.WIDTH(ENTRY_W), .DEPTH(DELTA_ENTRIES), .AW(DAW)) u_delta_ram (
    .clk   (clk),
    .we    (delta_we),
    .waddr (DAW'(f_idx)),
    .wdata (wr_entry),
    .raddr (issue_idx[DAW-1:0]),
    .rdata (delta_rd)
  );

  // Shared date compare on the entry read back.
  assign cur     = scan_sel ? tsol_entry_t'(delta_rd) : tsol_entry_t'(leap_rd);
  assign issuing = issue_idx < scan_n;
  assign early   = q_date[DATE_W-1:9] < cur.date[DATE_W-1:9];
  assign e_le    = cur.date <= q_date;
  assign e_gt    = cur.date > best.date;

  // Decode of a beat taken in idle.
  always_comb begin
    imm_off   = '0;
    imm_base  = '0;
    need_scan = 1'b0;
    imm_sel   = 1'b0;
    imm_n     = leap_n;
    if (act == ACT_QUERY) begin
      unique case (f_scale)
        SCALE_TAI: imm_off = BASE_TAI_MS;
        SCALE_GPS: imm_off = BASE_GPS_MS;
        SCALE_UTC: begin
          imm_off   = BASE_TAI_MS;
          imm_base  = BASE_TAI_MS;
          need_scan = (leap_n != '0);
        end
        SCALE_UT1: begin
          imm_sel   = 1'b1;
          imm_n     = delta_n;
          need_scan = (delta_n != '0);
        end
        default: imm_off = '0;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_acc && need_scan) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_pend && rd_first && early) begin
          state_next = ST_DONE;
        end else if (!issuing && !rd_pend) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_tready      = (state == ST_IDLE) && out_free;
    rd_pend_next  = (state == ST_SCAN) && issuing;
    out_load      = 1'b0;
    out_off_next  = imm_off;
    out_used_next = 1'b0;
    unique case (state)
      ST_IDLE: out_load = s_acc && !need_scan;
      ST_DONE: begin
        out_load      = out_free;
        out_used_next = found;
        out_off_next  = found ? base + {best.offset[EOFF_W-1], best.offset} : base;
      end
      default: out_load = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rd_pend     <= 1'b0;
      m_tvalid    <= 1'b0;
      leap_count  <= '0;
      delta_count <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_pend_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LEAP_COUNT:  leap_count  <= cfg_data[LCNT_W-1:0];
          CFG_DELTA_COUNT: delta_count <= cfg_data[DCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Scan datapath and output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_off  <= out_off_next;
      out_used <= out_used_next;
    end
    if (state == ST_IDLE) begin
      if (s_acc) begin
        q_date    <= f_date;
        scan_sel  <= imm_sel;
        scan_n    <= imm_n;
        base      <= imm_base;
        issue_idx <= '0;
        found     <= 1'b0;
      end
    end else if (state == ST_SCAN) begin
      if (issuing) begin
        issue_idx <= issue_idx + 1'b1;
      end
      rd_first <= issuing && (issue_idx == '0);
      if (rd_pend) begin
        if (rd_first) begin
          if (!early) begin
            found <= 1'b1;
            best  <= cur;
          end
        end else if (found && e_le && e_gt) begin
          best <= cur;
        end
      end
    end
  end

  assign m_tdata = {(M_DATA_W - OFF_W)'(0), out_off};
  assign m_tuser = out_used;

endmodule

`default_nettype wire

// File: sv/tsol_checker.sv
// Port-level assertions of the time-scale offset lookup, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tsol_checker import tsol_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tvalid,
  input wire logic                s_tready,
  input wire logic [S_DATA_W-1:0] s_tdata,
  input wire logic [1:0]          s_tuser,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [M_DATA_W-1:0] m_tdata,
  input wire logic                m_tuser
);

  // The output is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Input is only taken when the output register can take the result.
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || m_tready))
    else $error("ready while output is full");

  // A table write answers zero in the next cycle.
  a_write_answer: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == ACT_LEAP_WR || s_tuser == ACT_DELTA_WR)
    |=> m_tvalid && (m_tdata == '0) && !m_tuser)
    else $error("write beat did not answer zero");

  // A TAI query answers the fixed base in the next cycle.
  a_tai_answer: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == ACT_QUERY) &&
    (s_tdata[SCALE_LSB +: 3] == SCALE_TAI)
    |=> m_tvalid && (m_tdata[OFF_W-1:0] == BASE_TAI_MS) && !m_tuser)
    else $error("TAI query answered wrong");

endmodule

bind time_scale_offset_lookup_core tsol_checker u_tsol_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
